>>> rtl/tsm_pkg.sv
// Shared types and codes for the threaded stack machine core.
// Depends on nothing; the core and its testbench import it.

package tsm_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_RESTART = 2'd1,
        REQ_EXEC    = 2'd2
    } req_t;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_MUL     = 4'd1,
        OP_DROP    = 4'd2,
        OP_DUP     = 4'd3,
        OP_LIT     = 4'd4,
        OP_BRANCH  = 4'd5,
        OP_ZBRANCH = 4'd6,
        OP_CALL    = 4'd7,
        OP_RETURN  = 4'd8,
        OP_PRINT   = 4'd9,
        OP_HAIL    = 4'd10,
        OP_NEWLINE = 4'd11,
        OP_HALT    = 4'd12
    } op_t;

    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_PRINT   = 4'd1,
        ST_HAIL    = 4'd2,
        ST_NEWLINE = 4'd3,
        ST_HALTED  = 4'd4,
        ST_DOVF    = 4'd5,
        ST_DUND    = 4'd6,
        ST_ROVF    = 4'd7,
        ST_RUND    = 4'd8,
        ST_IGNORED = 4'd9
    } status_t;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [63:0] operand;
    } code_word_t;

endpackage

>>> rtl/tsm_in_if.sv
// Request channel of the stack machine core: valid/ready plus the request fields.
// Standalone; carries plain vectors.

interface tsm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [9:0]         addr;
    logic [3:0]         opcode;
    logic signed [63:0] operand;

    modport source (output valid, output req_type, output addr, output opcode,
                    output operand, input ready);
    modport sink   (input valid, input req_type, input addr, input opcode,
                    input operand, output ready);
endinterface

>>> rtl/tsm_out_if.sv
// Result channel of the stack machine core: valid/ready plus the result fields.
// Standalone; carries plain vectors.

interface tsm_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         status;
    logic signed [63:0] out_value;
    logic [9:0]         next_addr;

    modport source (output valid, output status, output out_value, output next_addr,
                    input ready);
    modport sink   (input valid, input status, input out_value, input next_addr,
                    output ready);
endinterface

>>> rtl/tsm_mul.sv
// Sequential 64-bit wrapping multiplier built on one shared 32x32 multiplier.
// Depends on nothing; used by threaded_stack_machine_core.

module tsm_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_LL,
        MUL_LH,
        MUL_HL,
        MUL_DONE
    } mul_state_t;

    mul_state_t  state_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [31:0] a_part;
    logic [31:0] b_part;
    logic [63:0] pp;

    // Only the low half of each cross product lands inside the 64-bit result.
    always_comb
    begin
        case (state_reg)
            MUL_LH:
            begin
                a_part = a_reg[31:0];
                b_part = b_reg[63:32];
            end
            MUL_HL:
            begin
                a_part = a_reg[63:32];
                b_part = b_reg[31:0];
            end
            default:
            begin
                a_part = a_reg[31:0];
                b_part = b_reg[31:0];
            end
        endcase
    end

    assign pp = a_part * b_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                MUL_IDLE, MUL_DONE:
                begin
                    if (start)
                    begin
                        a_reg     <= a;
                        b_reg     <= b;
                        state_reg <= MUL_LL;
                    end
                end
                MUL_LL:
                begin
                    acc_reg   <= pp;
                    state_reg <= MUL_LH;
                end
                MUL_LH:
                begin
                    acc_reg[63:32] <= acc_reg[63:32] + pp[31:0];
                    state_reg      <= MUL_HL;
                end
                MUL_HL:
                begin
                    acc_reg[63:32] <= acc_reg[63:32] + pp[31:0];
                    state_reg      <= MUL_DONE;
                end
                default:
                begin
                    state_reg <= MUL_IDLE;
                end
            endcase
        end
    end

    assign done    = (state_reg == MUL_DONE);
    assign product = acc_reg;

endmodule

>>> rtl/threaded_stack_machine_core.sv
// Threaded stack machine core: code memory, data and return stacks, one instruction per request.
// Depends on tsm_pkg, tsm_in_if, tsm_out_if and tsm_mul.
//
// Usage: requests arrive on req_ch (load a code word, restart at an address with both stacks
// emptied, or execute one instruction); each request produces exactly one result on rsp_ch
// with a status, the printed value (zero unless the status says printed) and the instruction
// pointer after the request. A transaction completes when valid and ready are both high.
// Flow: when a request is accepted, the code word, the entry below the top of the data stack
// and the top of the return stack are read from their memories into registers; the instruction
// then executes, writes back and loads the output register, waiting while the output register
// holds an untaken result or a multiply is running. A multiply steps the shared 32x32 multiplier
// through three partial products. No new request is accepted until the current one has executed.
// The top of the data stack lives in a register; the memory holds the entries below it.
// req_ch.ready stays low while a request is in execution, so reads never overlap a write.
// When rsp_ch stalls, one result waits in the output register and one more request may be
// accepted; it then waits until the result is taken.
// Reset clears the pointer, both stack depths and the halted flag. Code memory is undefined
// until written. CODE_DEPTH must be a power of two.

module threaded_stack_machine_core #(
    parameter int CODE_DEPTH   = 1024,
    parameter int DATA_DEPTH   = 32,
    parameter int RETURN_DEPTH = 32
)
(
    input logic       clk,
    input logic       rst_n,
    tsm_in_if.sink    req_ch,
    tsm_out_if.source rsp_ch
);

    import tsm_pkg::*;

    localparam int CW = $clog2(CODE_DEPTH);
    localparam int DA = $clog2(DATA_DEPTH);
    localparam int DW = $clog2(DATA_DEPTH + 1);
    localparam int RA = $clog2(RETURN_DEPTH);
    localparam int RW = $clog2(RETURN_DEPTH + 1);
    localparam logic [DW-1:0] DFULL = DW'(DATA_DEPTH);
    localparam logic [RW-1:0] RFULL = RW'(RETURN_DEPTH);

    code_word_t  code_mem [CODE_DEPTH];
    logic [63:0] data_mem [DATA_DEPTH];
    logic [CW-1:0] ret_mem [RETURN_DEPTH];

    // Request held for execution.
    logic        pend_reg;
    req_t        req_reg;
    logic [9:0]  addr_reg;
    logic [3:0]  opcode_reg;
    logic [63:0] operand_reg;

    // Memory read data.
    code_word_t    code_rd_reg;
    logic [63:0]   nos_rd_reg;
    logic [CW-1:0] ret_rd_reg;

    // Machine state.
    logic [CW-1:0] ip_reg, ip_next;
    logic [DW-1:0] dd_reg, dd_next;
    logic [RW-1:0] rd_reg, rd_next;
    logic          halted_reg, halted_next;
    logic [63:0]   tos_reg, tos_next;
    logic          mul_started_reg;

    // Output register.
    logic        out_valid_reg;
    status_t     status_reg, status_next;
    logic [63:0] value_reg, value_next;
    logic [9:0]  naddr_reg;

    logic          in_accept;
    logic          out_free;
    logic          fire;
    logic          is_mul_exec;
    logic          mul_start;
    logic          mul_done;
    logic [63:0]   mul_prod;
    op_t           op;
    logic [CW-1:0] seq_ip;
    logic [CW-1:0] target_ip;
    logic          code_we;
    logic          data_we;
    logic [DA-1:0] data_wa;
    logic [63:0]   data_wd;
    logic          ret_we;
    logic [RA-1:0] ret_wa;

    assign req_ch.ready = !pend_reg;
    assign in_accept    = req_ch.valid && !pend_reg;
    assign out_free     = !out_valid_reg || rsp_ch.ready;

    assign op          = op_t'(code_rd_reg.opcode);
    assign is_mul_exec = pend_reg && (req_reg == REQ_EXEC) && !halted_reg
                         && (op == OP_MUL) && (dd_reg >= DW'(2));
    assign mul_start   = is_mul_exec && !mul_started_reg;
    assign fire        = pend_reg && out_free
                         && (!is_mul_exec || (mul_started_reg && mul_done));

    assign seq_ip    = CW'(ip_reg + 1'b1);
    assign target_ip = CW'(code_rd_reg.operand);

    tsm_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (nos_rd_reg),
        .b       (tos_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb
    begin
        ip_next     = ip_reg;
        dd_next     = dd_reg;
        rd_next     = rd_reg;
        halted_next = halted_reg;
        tos_next    = tos_reg;
        status_next = ST_OK;
        value_next  = 64'd0;
        code_we     = 1'b0;
        data_we     = 1'b0;
        data_wa     = DA'(dd_reg - 1'b1);
        data_wd     = tos_reg;
        ret_we      = 1'b0;
        ret_wa      = RA'(rd_reg);

        case (req_reg)
            REQ_LOAD:
            begin
                code_we = (32'(addr_reg) < 32'(CODE_DEPTH));
            end
            REQ_RESTART:
            begin
                ip_next     = CW'(addr_reg);
                dd_next     = '0;
                rd_next     = '0;
                halted_next = 1'b0;
            end
            REQ_EXEC:
            begin
                if (halted_reg)
                begin
                    status_next = ST_IGNORED;
                end
                else
                begin
                    ip_next = seq_ip;
                    case (op)
                        OP_ADD, OP_MUL:
                        begin
                            if (dd_reg < DW'(2))
                            begin
                                status_next = ST_DUND;
                            end
                            else
                            begin
                                tos_next = (op == OP_ADD) ? (nos_rd_reg + tos_reg) : mul_prod;
                                dd_next  = dd_reg - 1'b1;
                            end
                        end
                        OP_DROP:
                        begin
                            if (dd_reg == '0)
                            begin
                                status_next = ST_DUND;
                            end
                            else
                            begin
                                tos_next = nos_rd_reg;
                                dd_next  = dd_reg - 1'b1;
                            end
                        end
                        OP_DUP:
                        begin
                            if (dd_reg == '0)
                            begin
                                status_next = ST_DUND;
                            end
                            else if (dd_reg == DFULL)
                            begin
                                status_next = ST_DOVF;
                            end
                            else
                            begin
                                data_we = 1'b1;
                                dd_next = dd_reg + 1'b1;
                            end
                        end
                        OP_LIT:
                        begin
                            if (dd_reg == DFULL)
                            begin
                                status_next = ST_DOVF;
                            end
                            else
                            begin
                                data_we  = (dd_reg != '0);
                                tos_next = code_rd_reg.operand;
                                dd_next  = dd_reg + 1'b1;
                            end
                        end
                        OP_BRANCH:
                        begin
                            ip_next = target_ip;
                        end
                        OP_ZBRANCH:
                        begin
                            if (dd_reg == '0)
                            begin
                                status_next = ST_DUND;
                            end
                            else
                            begin
                                tos_next = nos_rd_reg;
                                dd_next  = dd_reg - 1'b1;
                                if (tos_reg == 64'd0)
                                begin
                                    ip_next = target_ip;
                                end
                            end
                        end
                        OP_CALL:
                        begin
                            if (rd_reg == RFULL)
                            begin
                                status_next = ST_ROVF;
                            end
                            else
                            begin
                                ret_we  = 1'b1;
                                rd_next = rd_reg + 1'b1;
                                ip_next = target_ip;
                            end
                        end
                        OP_RETURN:
                        begin
                            if (rd_reg == '0)
                            begin
                                status_next = ST_RUND;
                            end
                            else
                            begin
                                rd_next = rd_reg - 1'b1;
                                ip_next = ret_rd_reg;
                            end
                        end
                        OP_PRINT:
                        begin
                            if (dd_reg == '0)
                            begin
                                status_next = ST_DUND;
                            end
                            else
                            begin
                                status_next = ST_PRINT;
                                value_next  = tos_reg;
                                tos_next    = nos_rd_reg;
                                dd_next     = dd_reg - 1'b1;
                            end
                        end
                        OP_HAIL:
                        begin
                            status_next = ST_HAIL;
                        end
                        OP_NEWLINE:
                        begin
                            status_next = ST_NEWLINE;
                        end
                        OP_HALT:
                        begin
                            status_next = ST_HALTED;
                            halted_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    // A stack fault halts the core and leaves the pointer on the faulting word.
                    if (status_next == ST_DOVF || status_next == ST_DUND
                        || status_next == ST_ROVF || status_next == ST_RUND)
                    begin
                        ip_next     = ip_reg;
                        dd_next     = dd_reg;
                        rd_next     = rd_reg;
                        tos_next    = tos_reg;
                        halted_next = 1'b1;
                        data_we     = 1'b0;
                        ret_we      = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg        <= 1'b0;
            mul_started_reg <= 1'b0;
            ip_reg          <= '0;
            dd_reg          <= '0;
            rd_reg          <= '0;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                pend_reg <= 1'b1;
            end
            else if (fire)
            begin
                pend_reg <= 1'b0;
            end

            if (mul_start)
            begin
                mul_started_reg <= 1'b1;
            end
            else if (fire)
            begin
                mul_started_reg <= 1'b0;
            end

            if (fire)
            begin
                ip_reg        <= ip_next;
                dd_reg        <= dd_next;
                rd_reg        <= rd_next;
                halted_reg    <= halted_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and memory ports.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg     <= req_t'(req_ch.req_type);
            addr_reg    <= req_ch.addr;
            opcode_reg  <= req_ch.opcode;
            operand_reg <= req_ch.operand;
            code_rd_reg <= code_mem[ip_reg];
            nos_rd_reg  <= data_mem[DA'(dd_reg - 2'd2)];
            ret_rd_reg  <= ret_mem[RA'(rd_reg - 1'b1)];
        end

        if (fire)
        begin
            tos_reg    <= tos_next;
            status_reg <= status_next;
            value_reg  <= value_next;
            naddr_reg  <= 10'(ip_next);
        end

        if (fire && code_we)
        begin
            code_mem[CW'(addr_reg)] <= '{opcode: opcode_reg, operand: operand_reg};
        end

        if (fire && data_we)
        begin
            data_mem[data_wa] <= data_wd;
        end

        if (fire && ret_we)
        begin
            ret_mem[ret_wa] <= seq_ip;
        end
    end

    assign rsp_ch.valid     = out_valid_reg;
    assign rsp_ch.status    = status_reg;
    assign rsp_ch.out_value = value_reg;
    assign rsp_ch.next_addr = naddr_reg;

`ifndef SYNTHESIS
    // A request in execution blocks the next one, so no read can overlap a write-back.
    a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !req_ch.ready)
        else $error("request accepted while another is in execution");

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (!out_valid_reg || rsp_ch.ready))
        else $error("result written over one that was not taken");

    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (status_next == ST_DOVF || status_next == ST_RUND)) |=> halted_reg)
        else $error("stack fault did not halt the core");

    a_mul_once: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |=> (!mul_start && !mul_done))
        else $error("multiplier started twice for one instruction");
`endif

endmodule

>>> tb/tb_threaded_stack_machine_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for threaded_stack_machine_core: directed and random
// request streams, checked against a behavioral mirror of the core.
// Depends on tsm_pkg, tsm_in_if, tsm_out_if and the core itself.

module tb_threaded_stack_machine_core;
    import tsm_pkg::*;

    localparam int CODE_DEPTH      = 1024;
    localparam int DATA_DEPTH      = 32;
    localparam int RETURN_DEPTH    = 32;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WINDOW_WORDS    = 24;

    // Request type that the core ignores.
    localparam logic [1:0]  REQ_NONE = 2'd3;
    localparam logic [63:0] MIN64    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64    = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  req_type;
        logic [9:0]  addr;
        logic [3:0]  opcode;
        logic [63:0] operand;
    } request_t;

    typedef struct {
        logic [3:0]  status;
        logic [63:0] value;
        logic [9:0]  next_addr;
    } result_t;

    class machine_mirror;
        logic [3:0]  code_op  [CODE_DEPTH];
        logic [63:0] code_arg [CODE_DEPTH];
        bit          loaded   [CODE_DEPTH];
        logic [63:0] dstack   [DATA_DEPTH];
        logic [9:0]  rstack   [RETURN_DEPTH];
        int          ddepth;
        int          rdepth;
        logic [9:0]  ip;
        bit          halted;
        result_t     results_due[$];
        int          mismatches;

        function new();
            ddepth     = 0;
            rdepth     = 0;
            ip         = '0;
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        // Executes the word under the pointer. Errors leave all state alone.
        function status_t run_word(output logic [63:0] printed);
            op_t        op;
            logic [63:0] arg;
            logic [9:0]  nxt;
            printed = '0;
            op      = op_t'(code_op[ip]);
            arg     = code_arg[ip];
            nxt     = ip + 10'd1;
            case (op)
                OP_ADD, OP_MUL:
                begin
                    if (ddepth < 2)
                        return ST_DUND;
                    if (op == OP_ADD)
                        dstack[ddepth - 2] = dstack[ddepth - 2] + dstack[ddepth - 1];
                    else
                        dstack[ddepth - 2] = dstack[ddepth - 2] * dstack[ddepth - 1];
                    ddepth--;
                end
                OP_DROP:
                begin
                    if (ddepth < 1)
                        return ST_DUND;
                    ddepth--;
                end
                OP_DUP:
                begin
                    if (ddepth < 1)
                        return ST_DUND;
                    if (ddepth >= DATA_DEPTH)
                        return ST_DOVF;
                    dstack[ddepth] = dstack[ddepth - 1];
                    ddepth++;
                end
                OP_LIT:
                begin
                    if (ddepth >= DATA_DEPTH)
                        return ST_DOVF;
                    dstack[ddepth] = arg;
                    ddepth++;
                end
                OP_BRANCH:
                    nxt = arg[9:0];
                OP_ZBRANCH:
                begin
                    if (ddepth < 1)
                        return ST_DUND;
                    ddepth--;
                    if (dstack[ddepth] == '0)
                        nxt = arg[9:0];
                end
                OP_CALL:
                begin
                    if (rdepth >= RETURN_DEPTH)
                        return ST_ROVF;
                    rstack[rdepth] = nxt;
                    rdepth++;
                    nxt = arg[9:0];
                end
                OP_RETURN:
                begin
                    if (rdepth < 1)
                        return ST_RUND;
                    rdepth--;
                    nxt = rstack[rdepth];
                end
                OP_PRINT:
                begin
                    if (ddepth < 1)
                        return ST_DUND;
                    ddepth--;
                    printed = dstack[ddepth];
                    ip      = nxt;
                    return ST_PRINT;
                end
                OP_HAIL:
                begin
                    ip = nxt;
                    return ST_HAIL;
                end
                OP_NEWLINE:
                begin
                    ip = nxt;
                    return ST_NEWLINE;
                end
                OP_HALT:
                begin
                    halted = 1'b1;
                    ip     = nxt;
                    return ST_HALTED;
                end
                default:
                    ;
            endcase
            ip = nxt;
            return ST_OK;
        endfunction

        function void take_request(request_t rq);
            result_t r;
            r.status = ST_OK;
            r.value  = '0;
            case (req_t'(rq.req_type))
                REQ_LOAD:
                begin
                    code_op[rq.addr]  = rq.opcode;
                    code_arg[rq.addr] = rq.operand;
                    loaded[rq.addr]   = 1'b1;
                end
                REQ_RESTART:
                begin
                    ip     = rq.addr;
                    ddepth = 0;
                    rdepth = 0;
                    halted = 1'b0;
                end
                REQ_EXEC:
                begin
                    if (halted)
                    begin
                        r.status = ST_IGNORED;
                    end
                    else
                    begin
                        r.status = run_word(r.value);
                        if (r.status >= ST_DOVF && r.status <= ST_RUND)
                            halted = 1'b1;
                    end
                end
                default:
                    ;
            endcase
            r.next_addr = ip;
            results_due.push_back(r);
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (results_due.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding: %0d %h %0d",
                         $time, got.status, got.value, got.next_addr);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
                mismatches++;
            end
            if (got.value !== want.value)
            begin
                $display("%0t: out_value expected %h, actual %h", $time, want.value, got.value);
                mismatches++;
            end
            if (got.next_addr !== want.next_addr)
            begin
                $display("%0t: next_addr expected %0d, actual %0d",
                         $time, want.next_addr, got.next_addr);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 29;
    int   recv_idle_pct = 60;

    // Random programs live in a small window of code memory so that branches loop back.
    logic [9:0] window_base = '0;
    bit         deep_mode = 1'b0;

    machine_mirror mirror = new();

    tsm_in_if  req_ch();
    tsm_out_if rsp_ch();

    threaded_stack_machine_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch),
        .rsp_ch (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin : result_sink
        result_t seen;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen.status    = rsp_ch.status;
            seen.value     = rsp_ch.out_value;
            seen.next_addr = rsp_ch.next_addr;
            mirror.match_result(seen);
        end
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic drive(input logic [1:0] kind, input logic [9:0] a,
                         input logic [3:0] op, input logic [63:0] arg);
        request_t rq;
        rq.req_type = kind;
        rq.addr     = a;
        rq.opcode   = op;
        rq.operand  = arg;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.addr     <= a;
        req_ch.opcode   <= op;
        req_ch.operand  <= arg;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        mirror.take_request(rq);
    endtask

    function automatic logic [63:0] random_literal();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return MIN64;
            3:       return MAX64;
            4:       return '1;
            5:       return 64'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] random_target();
        logic [9:0] spot;
        spot = window_base + 10'($urandom_range(0, WINDOW_WORDS - 1));
        case ($urandom_range(0, 9))
            0:       return {$urandom, $urandom};
            1, 2:    return {$urandom, 22'($urandom), spot};
            default: return {54'd0, spot};
        endcase
    endfunction

    function automatic logic [3:0] random_opcode();
        int pick;
        // Deep mode fills the window with pushes and calls, so the stacks run into their bounds.
        if (deep_mode)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4) return OP_LIT;
            if (pick < 6) return OP_DUP;
            if (pick < 8) return OP_CALL;
            return OP_BRANCH;
        end
        pick = $urandom_range(0, 99);
        if (pick < 20) return OP_LIT;
        if (pick < 30) return OP_DUP;
        if (pick < 38) return OP_ADD;
        if (pick < 44) return OP_MUL;
        if (pick < 50) return OP_DROP;
        if (pick < 56) return OP_BRANCH;
        if (pick < 63) return OP_ZBRANCH;
        if (pick < 71) return OP_CALL;
        if (pick < 78) return OP_RETURN;
        if (pick < 86) return OP_PRINT;
        if (pick < 90) return OP_HAIL;
        if (pick < 94) return OP_NEWLINE;
        if (pick < 97) return OP_HALT;
        return 4'(OP_HALT) + 4'($urandom_range(1, 3));
    endfunction

    function automatic request_t next_request();
        request_t rq;
        int       pick;
        rq.req_type = REQ_EXEC;
        rq.addr     = 10'($urandom);
        rq.opcode   = 4'($urandom);
        rq.operand  = {$urandom, $urandom};
        pick        = $urandom_range(0, 99);
        if ((mirror.halted && pick < 70) || (!mirror.halted && pick >= 90 && pick < 96))
        begin
            if ($urandom_range(0, 3) == 0)
                window_base = 10'($urandom);
            deep_mode   = ($urandom_range(0, 3) == 0);
            rq.req_type = REQ_RESTART;
            rq.addr     = window_base + 10'($urandom_range(0, WINDOW_WORDS - 1));
        end
        else if (!mirror.halted && pick >= 96)
        begin
            rq.req_type = REQ_NONE;
        end
        else if ((mirror.halted && pick < 85) || !mirror.loaded[mirror.ip] || pick >= 80)
        begin
            // Never execute an unwritten word: fill the pointer's address first.
            rq.req_type = REQ_LOAD;
            if (!mirror.halted && !mirror.loaded[mirror.ip])
                rq.addr = mirror.ip;
            else if ($urandom_range(0, 4) != 0)
                rq.addr = window_base + 10'($urandom_range(0, WINDOW_WORDS - 1));
            rq.opcode = random_opcode();
            if (rq.opcode == OP_BRANCH || rq.opcode == OP_ZBRANCH || rq.opcode == OP_CALL)
                rq.operand = random_target();
            else
                rq.operand = random_literal();
        end
        return rq;
    endfunction

    initial
    begin
        request_t rq;
        int       issued;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.addr     = '0;
        req_ch.opcode   = '0;
        req_ch.operand  = '0;
        rsp_ch.ready    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // A short program that walks through the extremes and most control flow:
        // wrap from the top address, add and multiply overflow, a zero branch whose
        // target has high bits set, call and return, print, halt, and execution while halted.
        drive(REQ_LOAD, 10'd1023, OP_LIT, MIN64);
        drive(REQ_LOAD, 10'd0, OP_DUP, '0);
        drive(REQ_LOAD, 10'd1, OP_ADD, '1);
        drive(REQ_LOAD, 10'd2, OP_ZBRANCH, {54'h3F_FFFF_FFFF_FFFF, 10'd4});
        drive(REQ_LOAD, 10'd4, OP_CALL, 64'd6);
        drive(REQ_LOAD, 10'd6, OP_LIT, MAX64);
        drive(REQ_LOAD, 10'd7, OP_LIT, '1);
        drive(REQ_LOAD, 10'd8, OP_MUL, '0);
        drive(REQ_LOAD, 10'd9, OP_RETURN, '0);
        drive(REQ_LOAD, 10'd5, OP_BRANCH, 64'd10);
        drive(REQ_LOAD, 10'd10, OP_PRINT, '0);
        drive(REQ_LOAD, 10'd11, OP_HALT, '0);
        drive(REQ_NONE, 10'd1023, '1, '1);
        drive(REQ_RESTART, 10'd1023, '0, '0);
        repeat (13)
            drive(REQ_EXEC, 10'($urandom), 4'($urandom), {$urandom, $urandom});

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 29 : 0;
            issued = 0;
            while (issued < ITEMS_PER_PHASE)
            begin
                rq = next_request();
                if (rq.req_type != REQ_NONE && !(rq.req_type == REQ_EXEC && mirror.halted))
                    issued++;
                drive(rq.req_type, rq.addr, rq.opcode, rq.operand);
            end
        end
        req_ch.valid <= 1'b0;

        while (mirror.results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: 5 ms, many times the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> threaded_stack_machine_core.f
rtl/tsm_pkg.sv
rtl/tsm_in_if.sv
rtl/tsm_out_if.sv
rtl/tsm_mul.sv
rtl/threaded_stack_machine_core.sv
tb/tb_threaded_stack_machine_core.sv
